// ----- rtl/mt64_pkg.sv -----
// Shared constants, types and word functions for the MT19937-64 generator.
package mt64_pkg;

   // Size of the generator state and the distance of the middle tap.
   localparam int STATE_WORDS = 312;
   localparam int MID_WORDS   = 156;
   localparam int INDEX_BITS  = $clog2(STATE_WORDS);

   // Widths of the bounded reduction.
   localparam int SPAN_BITS     = 33;
   localparam int DIVIDEND_BITS = 64;
   localparam int COUNT_BITS    = $clog2(DIVIDEND_BITS);

   // Twist and seeding constants.
   localparam logic [63:0] UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
   localparam logic [63:0] SEED_MULT    = 64'h5851_F42D_4C95_7F2D;
   localparam logic [63:0] RESET_SEED   = 64'd5489;

   // Tempering masks.
   localparam logic [63:0] TEMPER_MASK_A = 64'h5555_5555_5555_5555;
   localparam logic [63:0] TEMPER_MASK_B = 64'h71D6_7FFF_EDA6_0000;
   localparam logic [63:0] TEMPER_MASK_C = 64'hFFF7_EEE0_0000_0000;

   // Request codes.
   typedef enum logic [1:0] {
      MODE_RAW     = 2'd0,
      MODE_BOUNDED = 2'd1,
      MODE_RESEED  = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   // Status of the seeding sequencer towards the top level.
   typedef struct packed {
      logic push;
      logic busy;
   } seed_status_type;

   // Status of the serial remainder unit towards the top level.
   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

   // One step of the recurrence: x[k+312] = x[k+156] ^ mix(x[k], x[k+1]).
   function automatic logic [63:0] twist_word(input logic [63:0] hi_word,
                                              input logic [63:0] lo_word,
                                              input logic [63:0] mid_word);
      logic [63:0] joined;
      joined = (hi_word & UPPER_MASK) | (lo_word & LOWER_MASK);
      return mid_word ^ (joined >> 1) ^ (joined[0] ? TWIST_MATRIX : 64'd0);
   endfunction

   // Output tempering of one state word.
   function automatic logic [63:0] temper(input logic [63:0] word);
      logic [63:0] x;
      x = word;
      x = x ^ ((x >> 29) & TEMPER_MASK_A);
      x = x ^ ((x << 17) & TEMPER_MASK_B);
      x = x ^ ((x << 37) & TEMPER_MASK_C);
      x = x ^ (x >> 43);
      return x;
   endfunction

endpackage

// ----- rtl/mt64_cell.sv -----
// One stage of the state chain: holds a single 64-bit state word.
module mt64_cell import mt64_pkg::*; (
   input  logic        clock,
   input  logic        shift,
   input  logic [63:0] shift_word,
   output logic [63:0] word
);

   logic [63:0] word_ff;
   logic [63:0] word_in;

   // Take the neighbour's word whenever the chain advances.
   always_comb begin
      word_in = shift ? shift_word : word_ff;
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ----- rtl/mt64_seeder.sv -----
// Seeding sequencer: produces the 312 initial state words with one shared multiplier.
module mt64_seeder import mt64_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [63:0]     seed,
   output seed_status_type status,
   output logic [63:0]     push_word
);

   typedef enum logic [5:0] {
      SD_IDLE  = 6'b000001,
      SD_FIRST = 6'b000010,
      SD_MIX   = 6'b000100,
      SD_MUL0  = 6'b001000,
      SD_MUL1  = 6'b010000,
      SD_MUL2  = 6'b100000
   } seed_state_type;

   localparam logic [INDEX_BITS-1:0] LAST_INDEX = INDEX_BITS'(STATE_WORDS - 1);

   seed_state_type         state_ff, state_in;
   logic [INDEX_BITS-1:0]  index_ff, index_in;
   logic [63:0]            word_ff, word_in;
   logic [63:0]            mixed_ff, mixed_in;
   logic [63:0]            acc_ff, acc_in;
   logic [31:0]            mul_a, mul_b;
   logic [63:0]            product;
   logic [63:0]            next_word;

   // The 64-bit product modulo 2^64 is built from three 32 x 32 partial products.
   always_comb begin
      case (state_ff)
         SD_MUL1: begin
            mul_a = mixed_ff[63:32];
            mul_b = SEED_MULT[31:0];
         end
         SD_MUL2: begin
            mul_a = mixed_ff[31:0];
            mul_b = SEED_MULT[63:32];
         end
         default: begin
            mul_a = mixed_ff[31:0];
            mul_b = SEED_MULT[31:0];
         end
      endcase
   end

   assign product   = {32'd0, mul_a} * {32'd0, mul_b};
   assign next_word = {acc_ff[63:32] + product[31:0], acc_ff[31:0]};

   // Sequencer: the seed word first, then four steps for each further word.
   always_comb begin
      state_in = state_ff;
      index_in = index_ff;
      word_in  = word_ff;
      mixed_in = mixed_ff;
      acc_in   = acc_ff;
      case (state_ff)
         SD_IDLE: begin
            if (start) begin
               word_in  = seed;
               index_in = '0;
               state_in = SD_FIRST;
            end
         end
         SD_FIRST: begin
            index_in = index_ff + 1'b1;
            state_in = SD_MIX;
         end
         SD_MIX: begin
            mixed_in = word_ff ^ (word_ff >> 62);
            state_in = SD_MUL0;
         end
         SD_MUL0: begin
            acc_in   = product + 64'(index_ff);
            state_in = SD_MUL1;
         end
         SD_MUL1: begin
            acc_in   = next_word;
            state_in = SD_MUL2;
         end
         SD_MUL2: begin
            word_in = next_word;
            if (index_ff == LAST_INDEX) begin
               state_in = SD_IDLE;
            end else begin
               index_in = index_ff + 1'b1;
               state_in = SD_MIX;
            end
         end
         default: begin
            state_in = SD_IDLE;
         end
      endcase
   end

   // Reset starts a seeding pass from the reset seed.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SD_FIRST;
         index_ff <= '0;
         word_ff  <= RESET_SEED;
      end else begin
         state_ff <= state_in;
         index_ff <= index_in;
         word_ff  <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      mixed_ff <= mixed_in;
      acc_ff   <= acc_in;
   end

   assign status.push = (state_ff == SD_FIRST) || (state_ff == SD_MUL2);
   assign status.busy = (state_ff != SD_IDLE);
   assign push_word   = (state_ff == SD_FIRST) ? word_ff : next_word;

endmodule

// ----- rtl/mt64_mod_unit.sv -----
// Serial remainder unit: one dividend bit per cycle, restoring style.
module mt64_mod_unit import mt64_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [63:0]          dividend,
   input  logic [SPAN_BITS-1:0] divisor,
   output mod_status_type       status,
   output logic [31:0]          remainder
);

   localparam logic [COUNT_BITS-1:0] LAST_COUNT = COUNT_BITS'(DIVIDEND_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [63:0]           dividend_ff, dividend_in;
   logic [SPAN_BITS-1:0]  divisor_ff, divisor_in;
   logic [SPAN_BITS-1:0]  rem_ff, rem_in;
   logic [SPAN_BITS:0]    trial;
   logic                  fits;
   logic [SPAN_BITS-1:0]  rem_step;

   // Bring down the next dividend bit and subtract the divisor if it fits.
   assign trial    = {rem_ff, dividend_ff[63]};
   assign fits     = trial >= {1'b0, divisor_ff};
   assign rem_step = fits ? SPAN_BITS'(trial - {1'b0, divisor_ff}) : trial[SPAN_BITS-1:0];

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (start) begin
         busy_in     = 1'b1;
         count_in    = '0;
         dividend_in = dividend;
         divisor_in  = divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         rem_in      = rem_step;
         dividend_in = dividend_ff << 1;
         count_in    = count_ff + 1'b1;
         if (count_ff == LAST_COUNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   // The remainder is below the span, so it always fits in 32 bits.
   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff[31:0];

endmodule

// ----- rtl/mt19937_64_random_generator.sv -----
// Top level of the MT19937-64 generator: state chain, request control and result word.
// Raw draw: the request passes the draw and hand-over steps, and the result word is registered;
// the next request is taken back in idle. Equal bounds go straight to hand-over. Bounded draw:
// the serial remainder (64 steps) runs between draw and hand-over. Reseed gives no result.
// Reset is synchronous and starts the same seeding pass from seed 5489; no request is taken
// until it ends. A held result word adds its stall; the state chain shifts once per draw.
module mt19937_64_random_generator import mt64_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [63:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_range_min,
   input  logic signed [31:0] req_range_max,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_raw_value,
   output logic signed [31:0] rsp_bounded_value
);

   typedef enum logic [4:0] {
      ST_SEED = 5'b00001,
      ST_IDLE = 5'b00010,
      ST_DRAW = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_PUSH = 5'b10000
   } ctl_state_type;

   ctl_state_type        state_ff, state_in;
   logic [63:0]          csr_seed_ff, csr_seed_in;
   logic                 bounded_ff, bounded_in;
   logic signed [31:0]   lo_ff, lo_in;
   logic signed [31:0]   hi_ff, hi_in;
   logic [63:0]          res_raw_ff, res_raw_in;
   logic signed [31:0]   res_bounded_ff, res_bounded_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_raw_ff, rsp_raw_in;
   logic signed [31:0]   rsp_bounded_ff, rsp_bounded_in;

   logic                 accept;
   logic                 seed_start;
   logic                 draw_shift;
   logic                 mod_start;
   logic                 chain_shift;
   logic [63:0]          chain_tail;
   logic [63:0]          tail_word;
   logic [63:0]          drawn;
   logic [SPAN_BITS-1:0] span;
   logic [63:0]          seed_word;
   logic [31:0]          mod_rem;
   seed_status_type      seed_status;
   mod_status_type       mod_status;
   logic [63:0]          chain_word [STATE_WORDS];

   // Seed register.
   assign csr_seed_in = csr_wr_en ? csr_wr_data : csr_seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_seed_ff <= RESET_SEED;
      end else begin
         csr_seed_ff <= csr_seed_in;
      end
   end

   // State chain: cell 0 holds the oldest word, new words enter at the far end.
   generate
      for (genvar k = 0; k < STATE_WORDS; k++) begin : g_cell
         if (k == STATE_WORDS - 1) begin : g_tail
            mt64_cell u_cell (
               .clock      (clock),
               .shift      (chain_shift),
               .shift_word (chain_tail),
               .word       (chain_word[k])
            );
         end else begin : g_body
            mt64_cell u_cell (
               .clock      (clock),
               .shift      (chain_shift),
               .shift_word (chain_word[k+1]),
               .word       (chain_word[k])
            );
         end
      end
   endgenerate

   // Next word of the recurrence from the three fixed taps, and its tempered form.
   assign tail_word   = twist_word(chain_word[0], chain_word[1], chain_word[MID_WORDS]);
   assign drawn       = temper(tail_word);
   assign chain_shift = seed_status.push | draw_shift;
   assign chain_tail  = seed_status.push ? seed_word : tail_word;

   mt64_seeder u_seeder (
      .clock     (clock),
      .reset     (reset),
      .start     (seed_start),
      .seed      (csr_seed_ff),
      .status    (seed_status),
      .push_word (seed_word)
   );

   // The span is at most 2^32, so it is held in 33 bits.
   assign span = {hi_ff[31], hi_ff} - {lo_ff[31], lo_ff} + SPAN_BITS'(1);

   mt64_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (drawn),
      .divisor   (span),
      .status    (mod_status),
      .remainder (mod_rem)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Request control.
   always_comb begin
      state_in       = state_ff;
      bounded_in     = bounded_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      res_raw_in     = res_raw_ff;
      res_bounded_in = res_bounded_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_raw_in     = rsp_raw_ff;
      rsp_bounded_in = rsp_bounded_ff;
      seed_start     = 1'b0;
      draw_shift     = 1'b0;
      mod_start      = 1'b0;
      case (state_ff)
         ST_SEED: begin
            if (!seed_status.busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (mode_type'(req_mode))
                  MODE_RAW: begin
                     bounded_in = 1'b0;
                     state_in   = ST_DRAW;
                  end
                  MODE_BOUNDED: begin
                     if (req_range_min == req_range_max) begin
                        res_raw_in     = '0;
                        res_bounded_in = req_range_min;
                        state_in       = ST_PUSH;
                     end else begin
                        bounded_in = 1'b1;
                        // Reversed bounds are swapped.
                        if (req_range_max < req_range_min) begin
                           lo_in = req_range_max;
                           hi_in = req_range_min;
                        end else begin
                           lo_in = req_range_min;
                           hi_in = req_range_max;
                        end
                        state_in = ST_DRAW;
                     end
                  end
                  MODE_RESEED: begin
                     seed_start = 1'b1;
                     state_in   = ST_SEED;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DRAW: begin
            draw_shift     = 1'b1;
            res_raw_in     = drawn;
            res_bounded_in = '0;
            if (bounded_ff) begin
               mod_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_DIV: begin
            if (mod_status.done) begin
               res_bounded_in = lo_ff + mod_rem;
               state_in       = ST_PUSH;
            end
         end
         ST_PUSH: begin
            // Hand the result over once the output word is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_raw_in     = res_raw_ff;
               rsp_bounded_in = res_bounded_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bounded_ff     <= bounded_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      res_raw_ff     <= res_raw_in;
      res_bounded_ff <= res_bounded_in;
      rsp_raw_ff     <= rsp_raw_in;
      rsp_bounded_ff <= rsp_bounded_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_raw_value     = rsp_raw_ff;
   assign rsp_bounded_value = rsp_bounded_ff;

`ifndef SYNTH
   a_no_accept_while_seeding: assert property (@(posedge clock) disable iff (reset)
      seed_status.busy |-> !req_ready)
      else $error("Request accepted while the state is being seeded.");

   a_single_shift_source: assert property (@(posedge clock) disable iff (reset)
      !(seed_status.push && draw_shift))
      else $error("Seeding and drawing advanced the state chain together.");

   a_mod_done_in_div: assert property (@(posedge clock) disable iff (reset)
      mod_status.done |-> (state_ff == ST_DIV))
      else $error("Remainder finished outside the reduction step.");

   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_PUSH))
      else $error("Result word raised without passing through the hand-over step.");
`endif

endmodule
